[rtl/x86ma_pkg.sv]
// x86ma_pkg: word types and opcode constants for the modrm add execute block
// no dependencies; imported by the execute unit and its checker
`default_nettype none

package x86ma_pkg;

  // command opcodes
  localparam logic [2:0] OP_ADD_EB_GB = 3'd0;
  localparam logic [2:0] OP_ADD_EV_GV = 3'd1;
  localparam logic [2:0] OP_ADD_GB_EB = 3'd2;
  localparam logic [2:0] OP_LOAD_REG  = 3'd3;
  localparam logic [2:0] OP_LOAD_MEM  = 3'd4;

  // register load targets beyond the general registers
  localparam logic [3:0] TGT_DS = 4'd8;
  localparam logic [3:0] TGT_IP = 4'd9;

  // modrm mod field codes
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  // rm code that means a direct address under mod 0
  localparam logic [2:0] RM_DIRECT = 3'd6;

  // general register numbers used for addressing
  localparam logic [2:0] REG_BX = 3'd3;
  localparam logic [2:0] REG_BP = 3'd5;
  localparam logic [2:0] REG_SI = 3'd6;
  localparam logic [2:0] REG_DI = 3'd7;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] displacement;
    logic [3:0]  load_target;
    logic [15:0] load_value;
    logic [19:0] load_address;
  } x86ma_cmd_t;

  typedef struct packed {
    logic        dest_is_memory;
    logic [19:0] dest_address;
    logic        word_size;
    logic [15:0] result_value;
    logic [15:0] next_ip;
  } x86ma_rsp_t;

endpackage

`default_nettype wire

[rtl/x86_modrm_add_execute.sv]
// x86_modrm_add_execute: ADD with modrm addressing over general regs, DS, IP, byte memory
// depends on x86ma_pkg; data memory is two byte banks (even and odd addresses)
// pipeline: a command word passes the stage 1 register, then the output register
// throughput: one word per cycle while the output is not stalled; a memory-operand
//   add after a word that writes memory, or an add after a memory-form add Gb,Eb,
//   waits until that word leaves stage 1 (bank read-before-write, register interlock)
// reset: general registers, DS and IP cleared; data memory keeps its contents
`default_nettype none

module x86_modrm_add_execute #(
  parameter int MEM_ADDR_BITS = 12
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cmd_valid,
  output logic                  cmd_stall,
  input  x86ma_pkg::x86ma_cmd_t cmd,
  output logic                  rsp_valid,
  input  wire                   rsp_stall,
  output x86ma_pkg::x86ma_rsp_t rsp
);
  import x86ma_pkg::*;

  localparam int HALF_BITS  = MEM_ADDR_BITS - 1;
  localparam int BANK_DEPTH = 1 << HALF_BITS;

  typedef struct packed {
    logic                 mem_add;   // add with a memory operand, sum made here
    logic                 wr_mem;    // writes the data banks
    logic                 reg_dst;   // memory-form add Gb,Eb writes a byte reg
    logic                 word;
    logic [2:0]           reg_code;
    logic [15:0]          g_val;
    logic                 ma0;
    logic [HALF_BITS-1:0] e_addr;
    logic [HALF_BITS-1:0] o_addr;
    x86ma_rsp_t           rsp;
  } s1_t;

  // architectural state
  logic [15:0] regs [8];
  logic [15:0] data_seg;
  logic [15:0] ip;

  // data banks
  logic [7:0] mem_e [BANK_DEPTH];
  logic [7:0] mem_o [BANK_DEPTH];
  logic [7:0] even_q;
  logic [7:0] odd_q;

  logic s1_valid;
  s1_t  s1;
  s1_t  s1_next;
  logic s1_adv;
  logic acc;
  logic hazard;

  // decode fields
  logic [1:0]  modf;
  logic [2:0]  regf;
  logic [2:0]  rmf;
  logic        is_add;
  logic        word;
  logic        direct;
  logic        rd_mem;
  logic [15:0] base;
  logic [15:0] disp_ext;
  logic [2:0]  disp_len;
  logic [15:0] off;
  logic [19:0] phys;
  logic [15:0] e_val;
  logic [15:0] g_val;
  logic [15:0] reg_sum;
  logic [15:0] ip_next;

  logic [MEM_ADDR_BITS-1:0] ma;
  logic [HALF_BITS-1:0]     half;
  logic [HALF_BITS-1:0]     e_addr;

  // stage 1 signals
  logic [7:0]  lo_b;
  logic [7:0]  hi_b;
  logic [15:0] a_val;
  logic [15:0] s1_sum;
  logic [7:0]  wd_lo;
  logic [7:0]  wd_hi;
  logic        even_we;
  logic        odd_we;
  logic [7:0]  even_wd;
  logic [7:0]  odd_wd;
  logic        s1_reg_we;
  x86ma_rsp_t  rsp_next;

  function automatic logic [7:0] rd8(input logic [15:0] r, input logic hi);
    return hi ? r[15:8] : r[7:0];
  endfunction

  function automatic logic [15:0] wr8(input logic [15:0] r, input logic hi,
                                      input logic [7:0] v);
    return hi ? {v, r[7:0]} : {r[15:8], v};
  endfunction

  // field split and effective address
  always_comb begin
    modf   = cmd.modrm[7:6];
    regf   = cmd.modrm[5:3];
    rmf    = cmd.modrm[2:0];
    is_add = (cmd.opcode == OP_ADD_EB_GB) || (cmd.opcode == OP_ADD_EV_GV) ||
             (cmd.opcode == OP_ADD_GB_EB);
    word   = (cmd.opcode == OP_ADD_EV_GV);
    direct = (modf == MOD_NODISP) && (rmf == RM_DIRECT);
    rd_mem = is_add && (modf != MOD_REG);

    unique case (rmf)
      3'd0:    base = regs[REG_BX] + regs[REG_SI];
      3'd1:    base = regs[REG_BX] + regs[REG_DI];
      3'd2:    base = regs[REG_BP] + regs[REG_SI];
      3'd3:    base = regs[REG_BP] + regs[REG_DI];
      3'd4:    base = regs[REG_SI];
      3'd5:    base = regs[REG_DI];
      3'd6:    base = regs[REG_BP];
      default: base = regs[REG_BX];
    endcase

    unique case (modf)
      MOD_NODISP: begin
        disp_ext = direct ? cmd.displacement : 16'h0000;
        disp_len = direct ? 3'd2 : 3'd0;
      end
      MOD_DISP8: begin
        disp_ext = {{8{cmd.displacement[7]}}, cmd.displacement[7:0]};
        disp_len = 3'd1;
      end
      MOD_DISP16: begin
        disp_ext = cmd.displacement;
        disp_len = 3'd2;
      end
      default: begin
        disp_ext = 16'h0000;
        disp_len = 3'd0;
      end
    endcase

    off  = (direct ? 16'h0000 : base) + disp_ext;
    phys = {data_seg, 4'h0} + {4'h0, off};
  end

  // register operands and register-form sum
  always_comb begin
    e_val   = word ? regs[rmf]  : {8'h00, rd8(regs[rmf[1:0]], rmf[2])};
    g_val   = word ? regs[regf] : {8'h00, rd8(regs[regf[1:0]], regf[2])};
    reg_sum = e_val + g_val;
    if (!word) begin
      reg_sum[15:8] = 8'h00;
    end
  end

  // bank addresses: low byte at ma, high byte at ma + 1 in the other bank
  always_comb begin
    ma     = (cmd.opcode == OP_LOAD_MEM) ? cmd.load_address[MEM_ADDR_BITS-1:0]
                                         : phys[MEM_ADDR_BITS-1:0];
    half   = ma[MEM_ADDR_BITS-1:1];
    e_addr = ma[0] ? half + 1'b1 : half;
  end

  // stage 0 result and stage 1 payload
  always_comb begin
    s1_next          = '0;
    s1_next.word     = word;
    s1_next.reg_code = regf;
    s1_next.g_val    = g_val;
    s1_next.ma0      = ma[0];
    s1_next.e_addr   = e_addr;
    s1_next.o_addr   = half;
    s1_next.rsp      = '0;
    ip_next          = ip;

    unique case (cmd.opcode)
      OP_ADD_EB_GB, OP_ADD_EV_GV, OP_ADD_GB_EB: begin
        ip_next                  = ip + 16'd2 + {13'd0, disp_len};
        s1_next.rsp.word_size    = word;
        s1_next.rsp.result_value = reg_sum;
        if (modf == MOD_REG) begin
          s1_next.rsp.dest_address = (cmd.opcode == OP_ADD_GB_EB) ? {17'd0, regf}
                                                                   : {17'd0, rmf};
        end else if (cmd.opcode == OP_ADD_GB_EB) begin
          s1_next.mem_add          = 1'b1;
          s1_next.reg_dst          = 1'b1;
          s1_next.rsp.dest_address = {17'd0, regf};
        end else begin
          s1_next.mem_add            = 1'b1;
          s1_next.wr_mem             = 1'b1;
          s1_next.rsp.dest_is_memory = 1'b1;
          s1_next.rsp.dest_address   = phys;
        end
      end
      OP_LOAD_REG: begin
        s1_next.rsp.word_size    = 1'b1;
        s1_next.rsp.dest_address = {16'd0, cmd.load_target};
        if (cmd.load_target <= TGT_IP) begin
          s1_next.rsp.result_value = cmd.load_value;
        end
        if (cmd.load_target == TGT_IP) begin
          ip_next = cmd.load_value;
        end
      end
      OP_LOAD_MEM: begin
        s1_next.wr_mem             = 1'b1;
        s1_next.rsp.dest_is_memory = 1'b1;
        s1_next.rsp.dest_address   = cmd.load_address;
        s1_next.rsp.result_value   = {8'h00, cmd.load_value[7:0]};
      end
      default: begin
        s1_next.rsp = '0;
      end
    endcase
    s1_next.rsp.next_ip = ip_next;
  end

  // handshake and interlock
  always_comb begin
    s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
    hazard    = s1_valid && ((s1.wr_mem && rd_mem) || (s1.reg_dst && is_add));
    cmd_stall = !((!s1_valid || s1_adv) && !hazard);
    acc       = cmd_valid && !cmd_stall;
  end

  // stage 1: memory operand sum and write data
  always_comb begin
    lo_b   = s1.ma0 ? odd_q  : even_q;
    hi_b   = s1.ma0 ? even_q : odd_q;
    a_val  = s1.word ? {hi_b, lo_b} : {8'h00, lo_b};
    s1_sum = a_val + s1.g_val;
    if (!s1.word) begin
      s1_sum[15:8] = 8'h00;
    end
    wd_lo     = s1.mem_add ? s1_sum[7:0] : s1.rsp.result_value[7:0];
    wd_hi     = s1_sum[15:8];
    even_we   = s1_adv && s1.wr_mem && (s1.word || !s1.ma0);
    odd_we    = s1_adv && s1.wr_mem && (s1.word || s1.ma0);
    even_wd   = s1.ma0 ? wd_hi : wd_lo;
    odd_wd    = s1.ma0 ? wd_lo : wd_hi;
    // a stage 0 load of the same register replaces the stage 1 byte write
    s1_reg_we = s1_adv && s1.reg_dst &&
                !(acc && (cmd.opcode == OP_LOAD_REG) && (cmd.load_target < TGT_DS) &&
                  (cmd.load_target[2:0] == {1'b0, s1.reg_code[1:0]}));
    rsp_next  = s1.rsp;
    if (s1.mem_add) begin
      rsp_next.result_value = s1_sum;
    end
  end

  // data banks: read on accept, write when stage 1 retires
  always_ff @(posedge clk) begin
    if (acc && rd_mem) begin
      even_q <= mem_e[e_addr];
      odd_q  <= mem_o[half];
    end
    if (even_we) begin
      mem_e[s1.e_addr] <= even_wd;
    end
    if (odd_we) begin
      mem_o[s1.o_addr] <= odd_wd;
    end
  end

  // register file, DS and IP; a stage 0 write wins over an older stage 1 write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 16'h0000;
      end
      data_seg <= 16'h0000;
      ip       <= 16'h0000;
    end else begin
      if (s1_reg_we) begin
        regs[s1.reg_code[1:0]] <= wr8(regs[s1.reg_code[1:0]], s1.reg_code[2],
                                      s1_sum[7:0]);
      end
      if (acc) begin
        ip <= ip_next;
        if (is_add && (modf == MOD_REG)) begin
          if (cmd.opcode == OP_ADD_GB_EB) begin
            regs[regf[1:0]] <= wr8(regs[regf[1:0]], regf[2], reg_sum[7:0]);
          end else if (word) begin
            regs[rmf] <= reg_sum;
          end else begin
            regs[rmf[1:0]] <= wr8(regs[rmf[1:0]], rmf[2], reg_sum[7:0]);
          end
        end
        if (cmd.opcode == OP_LOAD_REG) begin
          if (cmd.load_target < TGT_DS) begin
            regs[cmd.load_target[2:0]] <= cmd.load_value;
          end else if (cmd.load_target == TGT_DS) begin
            data_seg <= cmd.load_value;
          end
        end
      end
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= s1_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[rtl/x86ma_checker.sv]
// x86ma_checker: port-level assertions for the modrm add execute block
// depends on x86ma_pkg; bound to x86_modrm_add_execute below
`default_nettype none

module x86ma_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   cmd_valid,
  input wire                   cmd_stall,
  input x86ma_pkg::x86ma_cmd_t cmd,
  input wire                   rsp_valid,
  input wire                   rsp_stall,
  input x86ma_pkg::x86ma_rsp_t rsp
);
  import x86ma_pkg::*;

  // no result word right after reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid right after reset");

  // every accepted command word is followed by a valid result word
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |-> ##2 rsp_valid)
    else $error("no result word two cycles after accept");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result word changed");

  // byte results carry no high byte
  a_byte_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.word_size |-> rsp.result_value[15:8] == 8'h00)
    else $error("byte result with a nonzero high byte");

  // register destinations are small indexes
  a_reg_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.dest_is_memory |-> rsp.dest_address[19:4] == 16'h0000)
    else $error("register destination index out of range");

endmodule

bind x86_modrm_add_execute x86ma_checker u_x86ma_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

[tb/sv/x86_modrm_add_execute_tb.sv]
// x86_modrm_add_execute_tb: self-checking bench for the modrm add execute block
// depends on x86ma_pkg and x86_modrm_add_execute; predicts every result word in
// order and compares it field by field, under several sender and receiver idling phases
`timescale 1ns / 1ps

module x86_modrm_add_execute_tb;
  import x86ma_pkg::*;

  localparam int MEM_BITS = 12;
  localparam int MEM_DEPTH = 1 << MEM_BITS;

  // opcodes beyond the load commands do nothing
  localparam logic [2:0] OP_NOP_FIRST = 3'd5;
  localparam logic [2:0] OP_NOP_LAST  = 3'd7;

  // load targets past IP are ignored
  localparam logic [3:0] TGT_FIRST_UNUSED = 4'd10;
  localparam logic [3:0] TGT_LAST_UNUSED  = 4'd15;

  // rm addressing forms (RM_DIRECT doubles as BP when mod is not 0)
  localparam logic [2:0] RM_BX_SI = 3'd0;
  localparam logic [2:0] RM_BX_DI = 3'd1;
  localparam logic [2:0] RM_BP_SI = 3'd2;
  localparam logic [2:0] RM_BP_DI = 3'd3;
  localparam logic [2:0] RM_SI    = 3'd4;
  localparam logic [2:0] RM_DI    = 3'd5;
  localparam logic [2:0] RM_BX    = 3'd7;

  // register codes used by the directed tests
  localparam logic [2:0] REG_AX = 3'd0;
  localparam logic [2:0] BR_CL  = 3'd1;
  localparam logic [2:0] BR_AH  = 3'd4;
  localparam logic [2:0] BR_BH  = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  x86ma_cmd_t cmd = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  x86ma_rsp_t rsp;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  // expected result words, oldest first
  x86ma_rsp_t pending_results[$];

  // architectural state as the block should hold it
  logic [15:0] gpr [8] = '{default: 16'h0000};
  logic [15:0] ds_reg = 16'h0000;
  logic [15:0] ip_reg = 16'h0000;
  logic [7:0]  mem_img [MEM_DEPTH];
  bit          mem_known [MEM_DEPTH];

  x86ma_cmd_t last_add = '0;
  bit         have_last_add = 1'b0;

  x86_modrm_add_execute #(.MEM_ADDR_BITS(MEM_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] byte_reg(input logic [2:0] code);
    return code[2] ? gpr[code[1:0]][15:8] : gpr[code[1:0]][7:0];
  endfunction

  task automatic set_byte_reg(input logic [2:0] code, input logic [7:0] v);
    if (code[2]) begin
      gpr[code[1:0]][15:8] = v;
    end else begin
      gpr[code[1:0]][7:0] = v;
    end
  endtask

  task automatic write_mem(input logic [19:0] pa, input logic [7:0] v);
    mem_img[pa[MEM_BITS-1:0]] = v;
    mem_known[pa[MEM_BITS-1:0]] = 1'b1;
  endtask

  // base/index plus displacement, 16-bit wrap
  function automatic logic [15:0] ea_offset(input logic [1:0] md, input logic [2:0] rm,
                                            input logic [15:0] disp);
    logic [15:0] base;
    logic [15:0] d;
    case (rm)
      RM_BX_SI:  base = gpr[REG_BX] + gpr[REG_SI];
      RM_BX_DI:  base = gpr[REG_BX] + gpr[REG_DI];
      RM_BP_SI:  base = gpr[REG_BP] + gpr[REG_SI];
      RM_BP_DI:  base = gpr[REG_BP] + gpr[REG_DI];
      RM_SI:     base = gpr[REG_SI];
      RM_DI:     base = gpr[REG_DI];
      RM_DIRECT: base = gpr[REG_BP];
      default:   base = gpr[REG_BX];
    endcase
    d = 16'h0000;
    if (md == MOD_NODISP) begin
      if (rm == RM_DIRECT) begin
        base = 16'h0000;
        d = disp;
      end
    end else if (md == MOD_DISP8) begin
      d = {{8{disp[7]}}, disp[7:0]};
    end else begin
      d = disp;
    end
    return base + d;
  endfunction

  function automatic logic [19:0] operand_addr(input x86ma_cmd_t c);
    return {ds_reg, 4'h0} + {4'h0, ea_offset(c.modrm[7:6], c.modrm[2:0], c.displacement)};
  endfunction

  function automatic logic [15:0] instr_len(input logic [1:0] md, input logic [2:0] rm);
    if (md == MOD_NODISP && rm == RM_DIRECT) return 16'd4;
    if (md == MOD_DISP8) return 16'd3;
    if (md == MOD_DISP16) return 16'd4;
    return 16'd2;
  endfunction

  // apply one accepted command to the state and form its result word
  task automatic retire_instruction(input x86ma_cmd_t c, output x86ma_rsp_t r);
    logic [1:0]  md;
    logic [2:0]  rg;
    logic [2:0]  rm;
    logic [19:0] pa;
    logic [19:0] pa_hi;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] sum;
    logic        wide;
    r = '0;
    md = c.modrm[7:6];
    rg = c.modrm[5:3];
    rm = c.modrm[2:0];
    if (c.opcode <= OP_ADD_GB_EB) begin
      wide = (c.opcode == OP_ADD_EV_GV);
      pa = operand_addr(c);
      pa_hi = pa + 20'd1;
      if (md == MOD_REG) begin
        a = wide ? gpr[rm] : {8'h00, byte_reg(rm)};
      end else if (wide) begin
        a = {mem_img[pa_hi[MEM_BITS-1:0]], mem_img[pa[MEM_BITS-1:0]]};
      end else begin
        a = {8'h00, mem_img[pa[MEM_BITS-1:0]]};
      end
      b = wide ? gpr[rg] : {8'h00, byte_reg(rg)};
      sum = a + b;
      if (!wide) sum[15:8] = 8'h00;
      if (c.opcode == OP_ADD_GB_EB) begin
        set_byte_reg(rg, sum[7:0]);
        r.dest_address = {17'd0, rg};
      end else if (md == MOD_REG) begin
        if (wide) gpr[rm] = sum;
        else set_byte_reg(rm, sum[7:0]);
        r.dest_address = {17'd0, rm};
      end else begin
        write_mem(pa, sum[7:0]);
        if (wide) write_mem(pa_hi, sum[15:8]);
        r.dest_is_memory = 1'b1;
        r.dest_address = pa;
      end
      r.word_size = wide;
      r.result_value = sum;
      ip_reg = ip_reg + instr_len(md, rm);
    end else if (c.opcode == OP_LOAD_REG) begin
      r.dest_address = {16'd0, c.load_target};
      r.word_size = 1'b1;
      if (c.load_target < TGT_DS) begin
        gpr[c.load_target[2:0]] = c.load_value;
        r.result_value = c.load_value;
      end else if (c.load_target == TGT_DS) begin
        ds_reg = c.load_value;
        r.result_value = c.load_value;
      end else if (c.load_target == TGT_IP) begin
        ip_reg = c.load_value;
        r.result_value = c.load_value;
      end
    end else if (c.opcode == OP_LOAD_MEM) begin
      write_mem(c.load_address, c.load_value[7:0]);
      r.dest_is_memory = 1'b1;
      r.dest_address = c.load_address;
      r.result_value = {8'h00, c.load_value[7:0]};
    end
    r.next_ip = ip_reg;
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    x86ma_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: %h", rsp);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("dest_is_memory", 20'(want.dest_is_memory), 20'(rsp.dest_is_memory));
        check_field("dest_address", want.dest_address, rsp.dest_address);
        check_field("word_size", 20'(want.word_size), 20'(rsp.word_size));
        check_field("result_value", 20'(want.result_value), 20'(rsp.result_value));
        check_field("next_ip", 20'(want.next_ip), 20'(rsp.next_ip));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic x86ma_cmd_t noise_cmd();
    x86ma_cmd_t c;
    c.opcode       = 3'($urandom_range(7));
    c.modrm        = 8'($urandom_range(255));
    c.displacement = 16'($urandom_range(16'hFFFF));
    c.load_target  = 4'($urandom_range(15));
    c.load_value   = 16'($urandom_range(16'hFFFF));
    c.load_address = 20'($urandom_range(20'hFFFFF));
    return c;
  endfunction

  function automatic x86ma_cmd_t add_cmd(input logic [2:0] op, input logic [1:0] md,
                                         input logic [2:0] rg, input logic [2:0] rm,
                                         input logic [15:0] disp);
    x86ma_cmd_t c;
    c = noise_cmd();
    c.opcode = op;
    c.modrm = {md, rg, rm};
    c.displacement = disp;
    return c;
  endfunction

  function automatic x86ma_cmd_t reg_load_cmd(input logic [3:0] tgt, input logic [15:0] v);
    x86ma_cmd_t c;
    c = noise_cmd();
    c.opcode = OP_LOAD_REG;
    c.load_target = tgt;
    c.load_value = v;
    return c;
  endfunction

  function automatic x86ma_cmd_t mem_load_cmd(input logic [19:0] pa, input logic [15:0] v);
    x86ma_cmd_t c;
    c = noise_cmd();
    c.opcode = OP_LOAD_MEM;
    c.load_address = pa;
    c.load_value = v;
    return c;
  endfunction

  // hold one command word until accepted, then record its expected result
  task automatic send_word(input x86ma_cmd_t c);
    x86ma_rsp_t want;
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    retire_instruction(c, want);
    pending_results.push_back(want);
  endtask

  // make sure a memory byte holds a written value before an add reads it
  task automatic preload_byte(input logic [19:0] pa);
    logic [19:0] alias_addr;
    if (!mem_known[pa[MEM_BITS-1:0]]) begin
      alias_addr = 20'($urandom_range(20'hFFFFF));
      alias_addr[MEM_BITS-1:0] = pa[MEM_BITS-1:0];
      send_word(mem_load_cmd(alias_addr, 16'($urandom_range(16'hFFFF))));
    end
  endtask

  // memory-operand adds get their source bytes loaded first
  task automatic send_instr(input x86ma_cmd_t c);
    logic [19:0] pa;
    if (c.opcode <= OP_ADD_GB_EB && c.modrm[7:6] != MOD_REG) begin
      pa = operand_addr(c);
      preload_byte(pa);
      if (c.opcode == OP_ADD_EV_GV) preload_byte(pa + 20'd1);
    end
    send_word(c);
  endtask

  task automatic pause_until_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_loads();
    send_instr(reg_load_cmd({1'b0, REG_AX}, 16'hFFFF));
    send_instr(reg_load_cmd({1'b0, REG_BX}, 16'h8001));
    send_instr(reg_load_cmd({1'b0, REG_SI}, 16'h7FFF));
    send_instr(reg_load_cmd({1'b0, REG_DI}, 16'h0000));
    send_instr(reg_load_cmd(TGT_DS, 16'hFFFF));
    send_instr(reg_load_cmd(TGT_IP, 16'hFFFE));
    // targets past IP leave the state alone
    send_instr(reg_load_cmd(TGT_LAST_UNUSED, 16'hFFFF));
    send_instr(reg_load_cmd(TGT_FIRST_UNUSED, 16'h1234));
  endtask

  task automatic test_memory_loads();
    send_instr(mem_load_cmd(20'hFFFFF, 16'hA5FF));
    send_instr(mem_load_cmd(20'h00000, 16'h5A01));
  endtask

  task automatic test_memory_forms();
    // direct word at the top of the address space, high byte wraps to zero, IP wraps
    send_instr(add_cmd(OP_ADD_EV_GV, MOD_NODISP, REG_AX, RM_DIRECT, 16'h000F));
    // negative disp8
    send_instr(add_cmd(OP_ADD_EB_GB, MOD_DISP8, BR_AH, RM_BX, 16'hAB80));
    // base plus index plus disp16 wraps the offset
    send_instr(add_cmd(OP_ADD_EV_GV, MOD_DISP16, REG_SI, RM_BX_SI, 16'hFFFF));
    // memory source into a high byte register
    send_instr(add_cmd(OP_ADD_GB_EB, MOD_NODISP, BR_BH, RM_SI, 16'h0000));
    // positive disp8 with high displacement byte ignored
    send_instr(add_cmd(OP_ADD_EB_GB, MOD_DISP8, BR_CL, RM_DI, 16'hFF7F));
  endtask

  task automatic test_register_forms();
    send_instr(add_cmd(OP_ADD_EB_GB, MOD_REG, BR_AH, BR_BH, 16'h0000));
    send_instr(add_cmd(OP_ADD_EV_GV, MOD_REG, REG_AX, REG_AX, 16'hFFFF));
    send_instr(add_cmd(OP_ADD_GB_EB, MOD_REG, BR_CL, BR_AH, 16'h1234));
  endtask

  task automatic test_no_operations();
    x86ma_cmd_t c;
    for (int op = int'(OP_NOP_FIRST); op <= int'(OP_NOP_LAST); op++) begin
      c = noise_cmd();
      c.opcode = 3'(op);
      send_instr(c);
    end
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    x86ma_cmd_t c;
    int pick;
    idle_pct = idle;
    stall_pct <= stall;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        c = reg_load_cmd(4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)));
      end else if (pick < 20) begin
        c = mem_load_cmd(20'($urandom_range(20'hFFFFF)), 16'($urandom_range(16'hFFFF)));
      end else if (pick < 26) begin
        c = noise_cmd();
      end else if (pick < 42 && have_last_add) begin
        // repeat the last add: reads back what it just wrote
        c = last_add;
      end else begin
        c = add_cmd(3'($urandom_range(OP_ADD_GB_EB)), 2'($urandom_range(3)),
                    3'($urandom_range(7)), 3'($urandom_range(7)),
                    16'($urandom_range(16'hFFFF)));
      end
      if (c.opcode <= OP_ADD_GB_EB) begin
        last_add = c;
        have_last_add = 1'b1;
      end
      send_instr(c);
    end
    pause_until_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_register_loads();
    test_memory_loads();
    test_memory_forms();
    test_register_forms();
    test_no_operations();
    pause_until_drained();
    // memory preloads add roughly two thirds on top of the random words
    test_random(75, 0, 0);
    test_random(75, 57, 0);
    test_random(75, 0, 57);
    test_random(75, 36, 36);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/x86ma_pkg.sv
rtl/x86_modrm_add_execute.sv
rtl/x86ma_checker.sv
tb/sv/x86_modrm_add_execute_tb.sv
